[hdl/pia_pkg.sv]
// ----------------------------------------------------------------------------
// pia_pkg
// Types and constants shared by the parallel interface adapter.
// ----------------------------------------------------------------------------
package pia_pkg;

   // Operation codes
   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_C1    = 3'd2;
   localparam logic [2:0] OP_C2    = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;

   // Register select
   localparam logic [1:0] ADDR_PORT_A = 2'd0;
   localparam logic [1:0] ADDR_CTL_A  = 2'd1;
   localparam logic [1:0] ADDR_PORT_B = 2'd2;
   localparam logic [1:0] ADDR_CTL_B  = 2'd3;

   localparam logic SIDE_A = 1'b0;
   localparam logic SIDE_B = 1'b1;

   // Control register bits
   localparam int CR_IRQ1_EN  = 0;
   localparam int CR_C1_POL   = 1;
   localparam int CR_PORT_SEL = 2;
   localparam int CR_C2_B3    = 3;
   localparam int CR_C2_B4    = 4;
   localparam int CR_C2_OUT   = 5;

   localparam logic [2:0] C2_MODE_C1_RESTORE = 3'b100;
   localparam logic [1:0] C2_MODE_STROBE     = 2'b10;

   // Strobe and restore delays in ticks
   localparam logic [5:0] STROBE_DELAY_A  = 6'd8;
   localparam logic [5:0] RESTORE_DELAY_A = 6'd24;
   localparam logic [5:0] STROBE_DELAY_B  = 6'd16;
   localparam logic [5:0] RESTORE_DELAY_B = 6'd48;

   localparam int IRQ_DELAY_TICKS_DEF = 14;

   typedef struct packed {
      logic [2:0] operation;
      logic [1:0] address;
      logic [7:0] write_data;
      logic       side;
      logic       level;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_a;
      logic       irq_b;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out_source;
      logic [7:0] port_b_out_sink;
      logic       ca2_out;
      logic       cb2_out_source;
      logic       cb2_out_sink;
   } rsp_type;

endpackage

[hdl/parallel_interface_adapter_core.sv]
// ----------------------------------------------------------------------------
// parallel_interface_adapter_core
// Two-port peripheral interface adapter, one operation per word.
// ----------------------------------------------------------------------------
// Each request word is one operation: bus read, bus write, C1 level change,
// C2 level sample or one timer tick. The word updates the side A and side B
// register state in a single pass of logic and the resulting read data, IRQ
// lines and pin drives land in a result register in the cycle after the request
// is accepted. One word is taken every clock; the
// only stall is a result word held by rsp_ready low, with the request side
// still open in the cycle the held word is taken. Interrupts assert
// IRQ_DELAY_TICKS tick operations after the active C1/C2 edge.
module parallel_interface_adapter_core #(
   parameter int IRQ_DELAY_TICKS = pia_pkg::IRQ_DELAY_TICKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pia_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pia_pkg::rsp_type rsp_payload
);
   import pia_pkg::*;

   localparam logic [7:0] IrqLoad = 8'(IRQ_DELAY_TICKS);

   logic [1:0][5:0] ctl_ff, ctl_in;
   logic [1:0][7:0] ddr_ff, ddr_in;
   logic [1:0][7:0] ord_ff, ord_in;
   logic [1:0]      c1_ff, c1_in;
   logic [1:0]      c2_ff, c2_in;
   logic [1:0]      f1_ff, f1_in;
   logic [1:0]      f2_ff, f2_in;
   logic [1:0]      irq_ff, irq_in;
   logic [1:0]      c2src_ff, c2src_in;
   logic [1:0]      c2snk_ff, c2snk_in;
   logic [1:0][7:0] irqcnt_ff, irqcnt_in;
   logic [1:0][5:0] stbcnt_ff, stbcnt_in;
   logic [1:0][5:0] rstcnt_ff, rstcnt_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    accept;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      logic [7:0] rd;
      logic [7:0] a_drive;
      logic [7:0] d;
      logic       sd;
      logic       do_c2;
      logic       c2_sd;
      logic       c2_lv;
      logic       v;
      logic [5:0] cr;

      ctl_in    = ctl_ff;
      ddr_in    = ddr_ff;
      ord_in    = ord_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      f1_in     = f1_ff;
      f2_in     = f2_ff;
      irq_in    = irq_ff;
      c2src_in  = c2src_ff;
      c2snk_in  = c2snk_ff;
      irqcnt_in = irqcnt_ff;
      stbcnt_in = stbcnt_ff;
      rstcnt_in = rstcnt_ff;

      rd      = 8'h00;
      a_drive = ~(~ord_ff[SIDE_A] & ddr_ff[SIDE_A]);
      d       = req_payload.write_data;
      sd      = req_payload.side;
      do_c2   = 1'b0;
      c2_sd   = req_payload.side;
      c2_lv   = req_payload.level;
      v       = 1'b1;
      cr      = '0;

      if (accept) begin
         unique case (req_payload.operation)
            OP_READ: begin
               unique case (req_payload.address)
                  ADDR_PORT_A: begin
                     if (!ctl_ff[SIDE_A][CR_PORT_SEL]) begin
                        rd = ddr_ff[SIDE_A];
                     end else begin
                        f1_in[SIDE_A]  = 1'b0;
                        f2_in[SIDE_A]  = 1'b0;
                        irq_in[SIDE_A] = 1'b0;
                        // port A read in strobe mode
                        if (ctl_ff[SIDE_A][CR_C2_OUT:CR_C2_B4] == C2_MODE_STROBE) begin
                           stbcnt_in[SIDE_A] = STROBE_DELAY_A;
                           rstcnt_in[SIDE_A] = ctl_ff[SIDE_A][CR_C2_B3] ?
                                               RESTORE_DELAY_A : 6'd0;
                        end
                        rd = a_drive & req_payload.port_a_pins;
                     end
                  end
                  ADDR_CTL_A: begin
                     rd = {f1_ff[SIDE_A], f2_ff[SIDE_A], ctl_ff[SIDE_A]};
                  end
                  ADDR_PORT_B: begin
                     if (!ctl_ff[SIDE_B][CR_PORT_SEL]) begin
                        rd = ddr_ff[SIDE_B];
                     end else begin
                        f1_in[SIDE_B]  = 1'b0;
                        f2_in[SIDE_B]  = 1'b0;
                        irq_in[SIDE_B] = 1'b0;
                        rd = (ord_ff[SIDE_B] & ddr_ff[SIDE_B]) |
                             (req_payload.port_b_pins & ~ddr_ff[SIDE_B]);
                     end
                  end
                  ADDR_CTL_B: begin
                     rd = {f1_ff[SIDE_B], f2_ff[SIDE_B], ctl_ff[SIDE_B]};
                  end
               endcase
            end
            OP_WRITE: begin
               unique case (req_payload.address)
                  ADDR_PORT_A: begin
                     if (!ctl_ff[SIDE_A][CR_PORT_SEL]) ddr_in[SIDE_A] = d;
                     else                               ord_in[SIDE_A] = d;
                  end
                  ADDR_PORT_B: begin
                     if (!ctl_ff[SIDE_B][CR_PORT_SEL]) begin
                        ddr_in[SIDE_B] = d;
                     end else begin
                        ord_in[SIDE_B] = d;
                        // port B write in strobe mode
                        if (ctl_ff[SIDE_B][CR_C2_OUT:CR_C2_B4] == C2_MODE_STROBE) begin
                           stbcnt_in[SIDE_B] = STROBE_DELAY_B;
                           rstcnt_in[SIDE_B] = ctl_ff[SIDE_B][CR_C2_B3] ?
                                               RESTORE_DELAY_B : 6'd0;
                        end
                     end
                  end
                  ADDR_CTL_A, ADDR_CTL_B: begin
                     sd         = req_payload.address[1];
                     ctl_in[sd] = d[5:0];
                     if (d[CR_C2_OUT]) f2_in[sd] = 1'b0;
                     if (d[CR_IRQ1_EN]) begin
                        irq_in[sd] = irq_ff[sd] | f1_ff[sd];
                     end else if (!d[CR_C2_OUT] && d[CR_C2_B3]) begin
                        irq_in[sd] = irq_ff[sd] | f2_in[sd];
                     end else begin
                        irq_in[sd] = 1'b0;
                     end
                     if (d[CR_C2_OUT]) begin
                        v            = d[CR_C2_B4] ? d[CR_C2_B3] : 1'b1;
                        c2snk_in[sd] = v;
                        if (sd == SIDE_B) c2src_in[sd] = v;
                     end else begin
                        c2snk_in[sd] = 1'b1;
                        if (sd == SIDE_B) c2src_in[sd] = 1'b0;
                        // C2 becomes an input: sample the supplied level
                        do_c2 = 1'b1;
                        c2_sd = sd;
                     end
                  end
               endcase
            end
            OP_C1: begin
               if (req_payload.level != c1_ff[sd]) begin
                  c1_in[sd] = req_payload.level;
                  if (ctl_ff[sd][CR_C1_POL] == req_payload.level) begin
                     if (ctl_ff[sd][CR_C2_OUT:CR_C2_B3] == C2_MODE_C1_RESTORE) begin
                        c2src_in[sd] = 1'b1;
                        c2snk_in[sd] = 1'b1;
                     end
                     f1_in[sd] = 1'b1;
                     if (ctl_ff[sd][CR_IRQ1_EN]) begin
                        if (irqcnt_ff[sd] == 8'd0) irqcnt_in[sd] = IrqLoad;
                     end else begin
                        irq_in[sd] = 1'b0;
                     end
                  end
               end
            end
            OP_C2: begin
               do_c2 = 1'b1;
            end
            OP_TICK: begin
               // per side: IRQ expiry, then restore, then strobe
               for (int s = 0; s < 2; s++) begin
                  if (irqcnt_ff[s] != 8'd0) begin
                     irqcnt_in[s] = irqcnt_ff[s] - 8'd1;
                     if (irqcnt_ff[s] == 8'd1) irq_in[s] = 1'b1;
                  end
                  if (rstcnt_ff[s] != 6'd0) begin
                     rstcnt_in[s] = rstcnt_ff[s] - 6'd1;
                     if (rstcnt_ff[s] == 6'd1) begin
                        c2src_in[s] = 1'b1;
                        c2snk_in[s] = 1'b1;
                     end
                  end
                  if (stbcnt_ff[s] != 6'd0) begin
                     stbcnt_in[s] = stbcnt_ff[s] - 6'd1;
                     if (stbcnt_ff[s] == 6'd1) begin
                        c2src_in[s] = 1'b0;
                        c2snk_in[s] = 1'b0;
                     end
                  end
               end
            end
            default: begin
               // unknown operation: hold all state
            end
         endcase

         if (do_c2) begin
            cr = ctl_in[c2_sd];
            if (cr[CR_C2_OUT]) begin
               f2_in[c2_sd] = 1'b0;
            end else if (c2_lv != c2_ff[c2_sd]) begin
               c2_in[c2_sd] = c2_lv;
               if (cr[CR_C2_B4] == c2_lv) begin
                  f2_in[c2_sd] = 1'b1;
                  if (cr[CR_C2_B3]) begin
                     if (irqcnt_in[c2_sd] == 8'd0) irqcnt_in[c2_sd] = IrqLoad;
                  end else begin
                     irq_in[c2_sd] = 1'b0;
                  end
               end
            end
         end
      end

      rsp_in.read_data         = rd;
      rsp_in.irq_a             = irq_in[SIDE_A];
      rsp_in.irq_b             = irq_in[SIDE_B];
      rsp_in.port_a_out        = ~(~ord_in[SIDE_A] & ddr_in[SIDE_A]);
      rsp_in.port_b_out_source = ord_in[SIDE_B] & ddr_in[SIDE_B];
      rsp_in.port_b_out_sink   = ord_in[SIDE_B] | ~ddr_in[SIDE_B];
      rsp_in.ca2_out           = c2snk_in[SIDE_A];
      rsp_in.cb2_out_source    = c2src_in[SIDE_B];
      rsp_in.cb2_out_sink      = c2snk_in[SIDE_B];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= '0;
         ddr_ff       <= '0;
         ord_ff       <= '0;
         c1_ff        <= '0;
         c2_ff        <= '0;
         f1_ff        <= '0;
         f2_ff        <= '0;
         irq_ff       <= '0;
         c2src_ff     <= '0;
         c2snk_ff     <= '1;
         irqcnt_ff    <= '0;
         stbcnt_ff    <= '0;
         rstcnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff    <= ctl_in;
         ddr_ff    <= ddr_in;
         ord_ff    <= ord_in;
         c1_ff     <= c1_in;
         c2_ff     <= c2_in;
         f1_ff     <= f1_in;
         f2_ff     <= f2_in;
         irq_ff    <= irq_in;
         c2src_ff  <= c2src_in;
         c2snk_ff  <= c2snk_in;
         irqcnt_ff <= irqcnt_in;
         stbcnt_ff <= stbcnt_in;
         rstcnt_ff <= rstcnt_in;
         if (accept)         rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   // every accepted word yields a result word in the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no result");

   // a result that is taken with nothing new behind it is gone
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !accept) |=> !rsp_valid)
      else $error("result repeated");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted over a held result");

   // IRQ countdown only runs from a load of the configured delay or below it
   a_irq_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (irqcnt_ff[SIDE_A] <= IrqLoad) && (irqcnt_ff[SIDE_B] <= IrqLoad))
      else $error("irq countdown out of range");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-port parallel interface adapter core.
// ----------------------------------------------------------------------------
// A short table of directed words runs first: reset values, direction and
// output registers, C2 output modes, strobe starts, changes on C1 and C2, the
// unused operation codes and a tick. Random sequences follow. They set up
// strobe mode on either side and run ticks and changes on C1 through the strobe
// and restore delays, or they arm interrupts and tick towards expiry. Some plain
// noise words are mixed in. A bit-level model of both sides predicts every
// result word. Both channels idle and stall at random.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pia_pkg::*;

   localparam int WORDS_TARGET = 1100;
   localparam int DRAIN_EVERY  = 250;
   localparam int IDLE_LIMIT   = 2000;
   localparam logic [7:0] IRQ_TICKS = 8'(IRQ_DELAY_TICKS_DEF);

   localparam rsp_type RSP_AT_RESET =
      rsp_type'{8'h00, 1'b0, 1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1};

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } step_row;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   parallel_interface_adapter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Adapter state as predicted, index 0 = side A, 1 = side B
   logic [5:0] ctl_r       [0:1];
   logic [7:0] ddr_r       [0:1];
   logic [7:0] out_r       [0:1];
   logic       c1_lvl      [0:1];
   logic       c2_lvl      [0:1];
   logic       flag1       [0:1];
   logic       flag2       [0:1];
   logic       irq_r       [0:1];
   logic       c2_src      [0:1];
   logic       c2_snk      [0:1];
   logic [7:0] irq_cnt     [0:1];
   logic [5:0] strobe_cnt  [0:1];
   logic [5:0] restore_cnt [0:1];

   rsp_type expected_q[$];
   step_row plan[$];

   int  fail_count      = 0;
   int  results_checked = 0;
   int  words_sent      = 0;
   int  idle_cycles     = 0;
   int  stall_left      = 0;
   bit  calm            = 1'b0;

   function automatic void reset_model();
      for (int i = 0; i < 2; i++) begin
         ctl_r[i] = '0;  ddr_r[i] = '0;  out_r[i] = '0;
         c1_lvl[i] = 0;  c2_lvl[i] = 0;  flag1[i] = 0;  flag2[i] = 0;
         irq_r[i] = 0;   c2_src[i] = 0;  c2_snk[i] = 1;
         irq_cnt[i] = '0;  strobe_cnt[i] = '0;  restore_cnt[i] = '0;
      end
   endfunction

   // A pending interrupt keeps its countdown
   function automatic void arm_irq(input logic sd);
      if (irq_cnt[sd] == '0)
         irq_cnt[sd] = IRQ_TICKS;
   endfunction

   function automatic void c1_edge(input logic sd, input logic lv);
      if (lv == c1_lvl[sd])
         return;
      c1_lvl[sd] = lv;
      if (ctl_r[sd][CR_C1_POL] != lv)
         return;
      if (ctl_r[sd][CR_C2_OUT -: 3] == C2_MODE_C1_RESTORE) begin
         c2_src[sd] = 1;
         c2_snk[sd] = 1;
      end
      flag1[sd] = 1;
      if (ctl_r[sd][CR_IRQ1_EN])
         arm_irq(sd);
      else
         irq_r[sd] = 0;
   endfunction

   function automatic void c2_edge(input logic sd, input logic lv);
      if (ctl_r[sd][CR_C2_OUT]) begin
         flag2[sd] = 0;
         return;
      end
      if (lv == c2_lvl[sd])
         return;
      c2_lvl[sd] = lv;
      if (ctl_r[sd][CR_C2_B4] != lv)
         return;
      flag2[sd] = 1;
      if (ctl_r[sd][CR_C2_B3])
         arm_irq(sd);
      else
         irq_r[sd] = 0;
   endfunction

   function automatic void start_strobe(input logic sd, input logic [5:0] strobe_at,
                                        input logic [5:0] restore_at);
      strobe_cnt[sd]  = strobe_at;
      restore_cnt[sd] = ctl_r[sd][CR_C2_B3] ? restore_at : 6'd0;
   endfunction

   function automatic void write_ctl(input logic sd, input logic [7:0] d, input logic lv);
      logic v;
      ctl_r[sd] = d[5:0];
      if (d[CR_C2_OUT])
         flag2[sd] = 0;
      if (ctl_r[sd][CR_IRQ1_EN])
         irq_r[sd] = irq_r[sd] | flag1[sd];
      else if (!ctl_r[sd][CR_C2_OUT] && ctl_r[sd][CR_C2_B3])
         irq_r[sd] = irq_r[sd] | flag2[sd];
      else
         irq_r[sd] = 0;
      if (d[CR_C2_OUT]) begin
         v = d[CR_C2_B4] ? d[CR_C2_B3] : 1'b1;
         c2_snk[sd] = v;
         if (sd == SIDE_B)
            c2_src[sd] = v;
      end else begin
         c2_snk[sd] = 1;
         if (sd == SIDE_B)
            c2_src[sd] = 0;
         c2_edge(sd, lv);
      end
   endfunction

   // Order matters: irq, then restore, then strobe
   function automatic void tick_side(input logic sd);
      if (irq_cnt[sd] != '0) begin
         irq_cnt[sd]--;
         if (irq_cnt[sd] == '0)
            irq_r[sd] = 1;
      end
      if (restore_cnt[sd] != '0) begin
         restore_cnt[sd]--;
         if (restore_cnt[sd] == '0) begin
            c2_src[sd] = 1;
            c2_snk[sd] = 1;
         end
      end
      if (strobe_cnt[sd] != '0) begin
         strobe_cnt[sd]--;
         if (strobe_cnt[sd] == '0) begin
            c2_src[sd] = 0;
            c2_snk[sd] = 0;
         end
      end
   endfunction

   function automatic rsp_type adapter_result(input req_type w);
      rsp_type    r;
      logic [7:0] a_drive;
      r = '0;
      a_drive = out_r[SIDE_A] | ~ddr_r[SIDE_A];
      case (w.operation)
         OP_READ: begin
            case (w.address)
               ADDR_PORT_A: begin
                  if (!ctl_r[SIDE_A][CR_PORT_SEL]) begin
                     r.read_data = ddr_r[SIDE_A];
                  end else begin
                     flag1[SIDE_A] = 0;  flag2[SIDE_A] = 0;  irq_r[SIDE_A] = 0;
                     if (ctl_r[SIDE_A][CR_C2_OUT -: 2] == C2_MODE_STROBE)
                        start_strobe(SIDE_A, STROBE_DELAY_A, RESTORE_DELAY_A);
                     r.read_data = a_drive & w.port_a_pins;
                  end
               end
               ADDR_CTL_A: r.read_data = {flag1[SIDE_A], flag2[SIDE_A], ctl_r[SIDE_A]};
               ADDR_PORT_B: begin
                  if (!ctl_r[SIDE_B][CR_PORT_SEL]) begin
                     r.read_data = ddr_r[SIDE_B];
                  end else begin
                     flag1[SIDE_B] = 0;  flag2[SIDE_B] = 0;  irq_r[SIDE_B] = 0;
                     r.read_data = (out_r[SIDE_B] & ddr_r[SIDE_B]) |
                                   (w.port_b_pins & ~ddr_r[SIDE_B]);
                  end
               end
               default: r.read_data = {flag1[SIDE_B], flag2[SIDE_B], ctl_r[SIDE_B]};
            endcase
         end
         OP_WRITE: begin
            case (w.address)
               ADDR_PORT_A: begin
                  if (!ctl_r[SIDE_A][CR_PORT_SEL])
                     ddr_r[SIDE_A] = w.write_data;
                  else
                     out_r[SIDE_A] = w.write_data;
               end
               ADDR_CTL_A: write_ctl(SIDE_A, w.write_data, w.level);
               ADDR_PORT_B: begin
                  if (!ctl_r[SIDE_B][CR_PORT_SEL]) begin
                     ddr_r[SIDE_B] = w.write_data;
                  end else begin
                     out_r[SIDE_B] = w.write_data;
                     if (ctl_r[SIDE_B][CR_C2_OUT -: 2] == C2_MODE_STROBE)
                        start_strobe(SIDE_B, STROBE_DELAY_B, RESTORE_DELAY_B);
                  end
               end
               default: write_ctl(SIDE_B, w.write_data, w.level);
            endcase
         end
         OP_C1: c1_edge(w.side, w.level);
         OP_C2: c2_edge(w.side, w.level);
         OP_TICK: begin
            tick_side(SIDE_A);
            tick_side(SIDE_B);
         end
         default: ;
      endcase
      r.irq_a             = irq_r[SIDE_A];
      r.irq_b             = irq_r[SIDE_B];
      r.port_a_out        = out_r[SIDE_A] | ~ddr_r[SIDE_A];
      r.port_b_out_source = out_r[SIDE_B] & ddr_r[SIDE_B];
      r.port_b_out_sink   = out_r[SIDE_B] | ~ddr_r[SIDE_B];
      r.ca2_out           = c2_snk[SIDE_A];
      r.cb2_out_source    = c2_src[SIDE_B];
      r.cb2_out_sink      = c2_snk[SIDE_B];
      return r;
   endfunction

   function automatic req_type mk_req(input logic [2:0] op, input logic [1:0] addr,
                                      input logic [7:0] data, input logic sd,
                                      input logic lv);
      req_type w;
      w.operation   = op;
      w.address     = addr;
      w.write_data  = data;
      w.side        = sd;
      w.level       = lv;
      w.port_a_pins = 8'($urandom);
      w.port_b_pins = 8'($urandom);
      return w;
   endfunction

   // Mostly short, now and then long
   function automatic int pause_len();
      return ($urandom_range(9) == 0) ? int'($urandom_range(8, 40))
                                      : int'($urandom_range(1, 3));
   endfunction

   task automatic add_row(input req_type w, input bit typed = 1'b0,
                          input rsp_type want = '0);
      plan.push_back(step_row'{w, typed, want});
   endtask

   // Drive one word, hold it until taken, then book its result
   task automatic issue(input req_type w, input bit typed = 1'b0,
                        input rsp_type want = '0);
      rsp_type predicted;
      int      gap;
      req_valid   <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = adapter_result(w);
      expected_q.push_back(typed ? want : predicted);
      if (w.operation <= OP_TICK)
         words_sent++;
      gap = (calm || $urandom_range(99) < 65) ? 0 : pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Valid is already low when nothing is outstanding
   task automatic drain();
      if (expected_q.size() != 0) begin
         req_valid <= 1'b0;
         while (expected_q.size() != 0)
            @(posedge clock);
      end
   endtask

   // Result side stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= pause_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      string   bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            if (fail_count < 10)
               $display("Result word with nothing expected: %p", rsp_payload);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            bad  = "";
            if (rsp_payload.read_data !== want.read_data)     bad = {bad, " read_data"};
            if (rsp_payload.irq_a !== want.irq_a)             bad = {bad, " irq_a"};
            if (rsp_payload.irq_b !== want.irq_b)             bad = {bad, " irq_b"};
            if (rsp_payload.port_a_out !== want.port_a_out)   bad = {bad, " port_a_out"};
            if (rsp_payload.port_b_out_source !== want.port_b_out_source)
               bad = {bad, " port_b_out_source"};
            if (rsp_payload.port_b_out_sink !== want.port_b_out_sink)
               bad = {bad, " port_b_out_sink"};
            if (rsp_payload.ca2_out !== want.ca2_out)         bad = {bad, " ca2_out"};
            if (rsp_payload.cb2_out_source !== want.cb2_out_source)
               bad = {bad, " cb2_out_source"};
            if (rsp_payload.cb2_out_sink !== want.cb2_out_sink)
               bad = {bad, " cb2_out_sink"};
            if (bad != "") begin
               if (fail_count < 10)
                  $display("Mismatch on result %0d:%s\n  got  %p\n  want %p",
                           results_checked, bad, rsp_payload, want);
               fail_count++;
            end
            results_checked++;
         end
      end
   end

   // Watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         kind;
      int         len;
      int         pick;
      int         next_drain;
      int         strobe_runs;
      int         irq_runs;
      int         directed;
      logic       sd;
      logic [1:0] port;
      logic [1:0] ctl;
      logic [2:0] kick;
      logic [2:0] op;
      logic [7:0] cfg;

      strobe_runs = 0;
      irq_runs    = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_ready   <= 1'b0;
      reset_model();

      add_row(mk_req(OP_READ, ADDR_CTL_A, 8'h00, SIDE_A, 1'b0), 1'b1, RSP_AT_RESET);
      add_row(mk_req(OP_READ, ADDR_PORT_B, 8'h00, SIDE_A, 1'b0), 1'b1, RSP_AT_RESET);
      add_row(mk_req(OP_WRITE, ADDR_PORT_A, 8'hFF, SIDE_A, 1'b0), 1'b1,
              rsp_type'{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1});
      add_row(mk_req(OP_READ, ADDR_PORT_A, 8'h00, SIDE_A, 1'b0), 1'b1,
              rsp_type'{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1});
      add_row(mk_req(OP_WRITE, ADDR_PORT_B, 8'h00, SIDE_B, 1'b0));
      // CB2 as output, driven high
      add_row(mk_req(OP_WRITE, ADDR_CTL_B, 8'h3F, SIDE_B, 1'b0), 1'b1,
              rsp_type'{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1});
      add_row(mk_req(OP_WRITE, ADDR_PORT_B, 8'hFF, SIDE_B, 1'b0), 1'b1,
              rsp_type'{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1});
      // CB2 as output, driven low
      add_row(mk_req(OP_WRITE, ADDR_CTL_B, 8'h30, SIDE_B, 1'b0), 1'b1,
              rsp_type'{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0});
      add_row(mk_req(OP_WRITE, ADDR_CTL_B, 8'h00, SIDE_B, 1'b0), 1'b1, RSP_AT_RESET ^
              rsp_type'{8'h00, 1'b0, 1'b0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0});
      add_row(mk_req(OP_WRITE, ADDR_PORT_B, 8'hFF, SIDE_B, 1'b0), 1'b1,
              rsp_type'{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1});
      // Strobe mode on B with timed restore, then a port write to start it
      add_row(mk_req(OP_WRITE, ADDR_CTL_B, 8'h2D, SIDE_B, 1'b0));
      add_row(mk_req(OP_WRITE, ADDR_PORT_B, 8'h00, SIDE_B, 1'b0));
      // C1 restore mode on A, rising C1 active, IRQ enabled
      add_row(mk_req(OP_WRITE, ADDR_CTL_A, 8'h27, SIDE_A, 1'b0));
      add_row(mk_req(OP_WRITE, ADDR_PORT_A, 8'hC3, SIDE_A, 1'b0));
      add_row(mk_req(OP_READ, ADDR_PORT_A, 8'h00, SIDE_A, 1'b0));
      add_row(mk_req(OP_C1, ADDR_PORT_A, 8'h00, SIDE_A, 1'b1));
      add_row(mk_req(OP_C2, ADDR_PORT_A, 8'h00, SIDE_B, 1'b1));
      add_row(mk_req(OP_C1, ADDR_PORT_A, 8'h00, SIDE_B, 1'b1));
      add_row(mk_req(OP_C1, ADDR_PORT_A, 8'h00, SIDE_B, 1'b0));
      add_row(mk_req(OP_TICK + 3'd1, ADDR_CTL_A, 8'hFF, SIDE_B, 1'b1));
      add_row(mk_req(OP_TICK + 3'd2, ADDR_CTL_B, 8'h00, SIDE_A, 1'b0));
      add_row(mk_req(OP_TICK + 3'd3, ADDR_PORT_B, 8'hFF, SIDE_B, 1'b1));
      add_row(mk_req(OP_TICK, ADDR_PORT_A, 8'h00, SIDE_A, 1'b0));
      // C2 input, rising active with IRQ; edge arrives with the write
      add_row(mk_req(OP_WRITE, ADDR_CTL_A, 8'h18, SIDE_A, 1'b1));
      add_row(mk_req(OP_READ, ADDR_CTL_A, 8'h00, SIDE_A, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         issue(plan[i].req, plan[i].typed, plan[i].want);
      directed = words_sent;
      drain();

      next_drain = words_sent + DRAIN_EVERY;
      while (words_sent < WORDS_TARGET) begin
         if (words_sent >= next_drain) begin
            drain();
            next_drain += DRAIN_EVERY;
         end
         calm <= ($urandom_range(99) < 15);
         kind = $urandom_range(9);
         if (kind < 5) begin
            // Strobe: configure, start it, then let ticks and changes on C1 play out
            sd   = (kind < 3) ? SIDE_A : SIDE_B;
            port = sd ? ADDR_PORT_B : ADDR_PORT_A;
            ctl  = sd ? ADDR_CTL_B : ADDR_CTL_A;
            kick = sd ? OP_WRITE : OP_READ;
            issue(mk_req(OP_WRITE, ctl,
                         {2'($urandom), C2_MODE_STROBE, 1'($urandom), 1'b1, 2'($urandom)},
                         sd, 1'($urandom)));
            issue(mk_req(OP_WRITE, port, 8'($urandom), sd, 1'b0));
            issue(mk_req(kick, port, 8'($urandom), sd, 1'b0));
            len = $urandom_range(4, sd ? 60 : 32);
            repeat (len) begin
               pick = $urandom_range(19);
               op   = (pick < 14) ? OP_TICK : ((pick < 17) ? OP_C1 : kick);
               issue(mk_req(op, port, 8'($urandom), sd, 1'($urandom)));
            end
            strobe_runs++;
         end else if (kind < 7) begin
            // Interrupts: configure one side, then a random mix of ticks, edges and reads on it
            sd  = 1'($urandom);
            cfg = 8'($urandom);
            cfg[CR_PORT_SEL] = 1'b1;
            if ($urandom_range(3) != 0)
               cfg[CR_C2_OUT] = 1'b0;
            issue(mk_req(OP_WRITE, sd ? ADDR_CTL_B : ADDR_CTL_A, cfg, sd, 1'($urandom)));
            len = $urandom_range(10, 40);
            repeat (len) begin
               pick = $urandom_range(19);
               op   = (pick < 9) ? OP_TICK : ((pick < 14) ? OP_C1 :
                      ((pick < 18) ? OP_C2 : OP_READ));
               issue(mk_req(op, {sd, 1'($urandom)}, 8'($urandom), sd, 1'($urandom)));
            end
            irq_runs++;
         end else begin
            repeat ($urandom_range(1, 8)) begin
               pick = $urandom_range(99);
               if (pick < 20)      op = OP_READ;
               else if (pick < 45) op = OP_WRITE;
               else if (pick < 60) op = OP_C1;
               else if (pick < 72) op = OP_C2;
               else if (pick < 97) op = OP_TICK;
               else                op = OP_TICK + 3'($urandom_range(1, 3));
               issue(mk_req(op, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d words (%0d directed), checked %0d results", words_sent,
               directed, results_checked);
      $display("Random part: %0d strobe sequences, %0d interrupt sequences, %0d mismatches",
               strobe_runs, irq_runs, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
